>>> design/i2c_eeprom_master_defines.svh
// Assertion macros shared by the I2C EEPROM master checker.
`ifndef I2C_EEPROM_MASTER_DEFINES_SVH
`define I2C_EEPROM_MASTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CEE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c_eeprom_master check failed");

// Next-cycle implication, disabled during reset.
`define I2CEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c_eeprom_master check failed");

`endif

>>> design/i2cee_pkg.sv
// Types, codes and small decode functions for the I2C EEPROM master.
package i2cee_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SEG_START = 2'd0,
    SEG_TX    = 2'd1,
    SEG_RX    = 2'd2,
    SEG_STOP  = 2'd3
  } seg_t;

  // Request kinds on the input channel
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_PHASE_TICKS    = 1'b1;

  localparam logic [6:0]  DEV_ADDR_RST    = 7'd80;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

  // Segment programs
  localparam logic [2:0] READ_LAST_SEG  = 3'd6;
  localparam logic [2:0] WRITE_LAST_SEG = 3'd4;
  localparam logic [3:0] ACK_SLOT       = 4'd8;
  localparam logic [1:0] SUB_LAST       = 2'd2;

  typedef struct packed {
    logic scl;
    logic sda;
    logic smp_ack;
    logic smp_bit;
    logic last;
  } phase_t;

  function automatic seg_t seg_kind(input logic is_read, input logic [2:0] seg);
    seg_t k;
    k = SEG_TX;
    if (is_read) begin
      case (seg)
        3'd0, 3'd3: k = SEG_START;
        3'd5:       k = SEG_RX;
        3'd6:       k = SEG_STOP;
        default:    k = SEG_TX;
      endcase
    end else begin
      case (seg)
        3'd0:    k = SEG_START;
        3'd4:    k = SEG_STOP;
        default: k = SEG_TX;
      endcase
    end
    return k;
  endfunction

endpackage

>>> design/i2c_eeprom_master.sv
// I2C EEPROM master: bus phase sequencer, one tick item in and one status item out.
// The status item of an accepted tick is in the output register in the cycle after it is taken.
// Throughput: one tick per cycle; a new tick is taken whenever the output register is
// empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): sequencer idle, lines released, flags and read byte
// cleared, device address 80 and phase length 100 ticks.
module i2c_eeprom_master
  import i2cee_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic [23:0] in_tdata,   // [7:0] word_address, [15:8] write_data, [16] sda_in
  // Status results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,  // done_res
  output logic [15:0] out_tdata,  // [0] scl_level, [1] sda_level, [2] busy_res,
                                  // [10:3] read_byte, [11] nack_seen
  // Configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  mode_t       mode_r, mode_nxt;
  logic [2:0]  seg_r, seg_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  received_r, received_nxt;
  logic        nack_r, nack_nxt;
  logic        done_r, done_nxt;
  logic        out_valid_r;
  logic [6:0]  dev_addr_r;
  logic [15:0] phase_ticks_r;

  logic        accept;
  logic        is_read;
  logic        busy;
  seg_t        kind_of_seg;
  logic [7:0]  dev_w;
  logic [7:0]  tx_byte;
  phase_t      ph;
  logic [16:0] pt_eff;
  logic        phase_end;
  logic [7:0]  f_word_address;
  logic [7:0]  f_write_data;
  logic        f_sda_in;

  assign f_word_address = in_tdata[7:0];
  assign f_write_data   = in_tdata[15:8];
  assign f_sda_in       = in_tdata[16];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign is_read     = (mode_r == MODE_READ);
  assign busy        = (mode_r != MODE_IDLE);
  assign kind_of_seg = seg_kind(is_read, seg_r);
  assign dev_w       = {dev_addr_r, 1'b0};

  always_comb begin
    case (seg_r)
      3'd1:    tx_byte = dev_w;
      3'd2:    tx_byte = addr_r;
      default: tx_byte = is_read ? (dev_w | 8'h01) : data_r;
    endcase
  end

  // Decode the line levels and sample points of the current phase
  always_comb begin
    ph = '0;
    ph.last = (seg_r == (is_read ? READ_LAST_SEG : WRITE_LAST_SEG)) && (sub_r == SUB_LAST);
    case (kind_of_seg)
      SEG_START: begin
        ph.scl = (sub_r != 2'd2);
        ph.sda = (sub_r == 2'd0);
      end
      SEG_STOP: begin
        ph.scl = (sub_r != 2'd0);
        ph.sda = (sub_r == 2'd2);
      end
      SEG_TX: begin
        ph.scl = (sub_r == 2'd1);
        if (slot_r == ACK_SLOT) begin
          ph.sda     = 1'b1;
          ph.smp_ack = (sub_r == 2'd1);
        end else begin
          ph.sda = tx_byte[~slot_r[2:0]];
        end
      end
      SEG_RX: begin
        ph.scl     = (sub_r == 2'd1);
        ph.sda     = 1'b1;
        ph.smp_bit = (sub_r == 2'd1) && (slot_r != ACK_SLOT);
      end
      default: ph = '0;
    endcase
  end

  assign pt_eff    = (phase_ticks_r == 16'd0) ? 17'd1 : {1'b0, phase_ticks_r};
  assign phase_end = ({1'b0, timer_r} + 17'd1) >= pt_eff;

  always_comb begin
    mode_nxt     = mode_r;
    seg_nxt      = seg_r;
    slot_nxt     = slot_r;
    sub_nxt      = sub_r;
    timer_nxt    = timer_r;
    shift_nxt    = shift_r;
    addr_nxt     = addr_r;
    data_nxt     = data_r;
    received_nxt = received_r;
    nack_nxt     = nack_r;
    done_nxt     = done_r;
    if (accept) begin
      done_nxt = 1'b0;
      if (!busy) begin
        if ((in_tuser == KIND_READ) || (in_tuser == KIND_WRITE)) begin
          addr_nxt  = f_word_address;
          data_nxt  = f_write_data;
          nack_nxt  = 1'b0;
          shift_nxt = '0;
          seg_nxt   = '0;
          slot_nxt  = '0;
          sub_nxt   = '0;
          timer_nxt = '0;
          mode_nxt  = (in_tuser == KIND_READ) ? MODE_READ : MODE_WRITE;
        end
      end else if (phase_end) begin
        if (ph.smp_ack && f_sda_in) begin
          nack_nxt = 1'b1;
        end
        if (ph.smp_bit) begin
          shift_nxt = {shift_r[6:0], f_sda_in};
        end
        timer_nxt = '0;
        if (ph.last) begin
          if (is_read) begin
            received_nxt = shift_r;
          end
          mode_nxt = MODE_IDLE;
          seg_nxt  = '0;
          slot_nxt = '0;
          sub_nxt  = '0;
          done_nxt = 1'b1;
        end else if (sub_r != SUB_LAST) begin
          sub_nxt = sub_r + 2'd1;
        end else begin
          sub_nxt = '0;
          // Start/stop segments and the ack slot close the segment
          if ((kind_of_seg == SEG_START) || (kind_of_seg == SEG_STOP) ||
              (slot_r == ACK_SLOT)) begin
            slot_nxt = '0;
            seg_nxt  = seg_r + 3'd1;
          end else begin
            slot_nxt = slot_r + 4'd1;
          end
        end
      end else begin
        timer_nxt = timer_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      seg_r         <= '0;
      slot_r        <= '0;
      sub_r         <= '0;
      timer_r       <= '0;
      shift_r       <= '0;
      addr_r        <= '0;
      data_r        <= '0;
      received_r    <= '0;
      nack_r        <= 1'b0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      dev_addr_r    <= DEV_ADDR_RST;
      phase_ticks_r <= PHASE_TICKS_RST;
    end else begin
      mode_r     <= mode_nxt;
      seg_r      <= seg_nxt;
      slot_r     <= slot_nxt;
      sub_r      <= sub_nxt;
      timer_r    <= timer_nxt;
      shift_r    <= shift_nxt;
      addr_r     <= addr_nxt;
      data_r     <= data_nxt;
      received_r <= received_nxt;
      nack_r     <= nack_nxt;
      done_r     <= done_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEVICE_ADDRESS: dev_addr_r    <= cfg_wdata[6:0];
          REG_PHASE_TICKS:    phase_ticks_r <= cfg_wdata;
          default:            phase_ticks_r <= phase_ticks_r;
        endcase
      end
    end
  end

  // State only moves on an accepted tick, so the status item holds while stalled unless the configuration is written
  assign out_tvalid = out_valid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {4'd0, nack_r, received_r, busy,
                       busy ? ph.sda : 1'b1, busy ? ph.scl : 1'b1};

endmodule

>>> design/i2cee_checker.sv
// Port-level checks for the I2C EEPROM master, bound to the top level.
`include "i2c_eeprom_master_defines.svh"

module i2cee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tlast,
  input logic [15:0] out_tdata
);

  `I2CEE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `I2CEE_ASSERT_NEXT(a_in_to_out, clk, rst_n, in_tvalid && in_tready, out_tvalid)
  `I2CEE_ASSERT_NOW(a_done_idle, clk, rst_n, out_tvalid && out_tlast, out_tdata[2:0] == 3'b011)
  `I2CEE_ASSERT_NOW(a_idle_released, clk, rst_n, out_tvalid && !out_tdata[2], out_tdata[1:0] == 2'b11)

endmodule

bind i2c_eeprom_master i2cee_checker u_i2cee_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tdata  (out_tdata)
);
